FILE: rtl/core/dai_pkg.sv
package dai_pkg;

	localparam int COORD_WIDTH_DEF    = 24;
	localparam int GAIN_FRAC_BITS_DEF = 15;
	localparam int ROLLOFF_W          = 16;
	localparam int CFG_INDEX_W        = 2;

	typedef enum logic [1:0] {
		KIND_CALC,
		KIND_ONE,
		KIND_ZERO
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LISTENER_X,
		CFG_LISTENER_Y,
		CFG_LISTENER_Z
	} cfg_idx_t;

endpackage

FILE: rtl/core/dai_sqdist.sv
module dai_sqdist
	import dai_pkg::*;
#(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [CW-1:0]        src_x,
	input  logic [CW-1:0]        src_y,
	input  logic [CW-1:0]        src_z,
	input  logic [CW-1:0]        lis_x,
	input  logic [CW-1:0]        lis_y,
	input  logic [CW-1:0]        lis_z,
	input  logic [CW-1:0]        min_distance,
	input  logic [CW-1:0]        max_distance,
	input  logic [ROLLOFF_W-1:0] rolloff,
	input  logic                 is_spatial,
	output logic                 out_valid,
	output logic [2*CW-1:0]      sq,
	output logic [CW-1:0]        mn,
	output logic [ROLLOFF_W-1:0] ro,
	output kind_t                kind
);

	localparam int SW = 2 * CW + 3;

	logic [CW:0] dx, dy, dz;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [CW:0]          ax_s1, ay_s1, az_s1;
	logic [CW-1:0]        mn_s1, mx_s1, mn_s2, mn_s3, mn_s4;
	logic [ROLLOFF_W-1:0] ro_s1, ro_s2, ro_s3, ro_s4;
	logic                 sp_s1, sp_s2, sp_s3;
	logic [2*CW+1:0]      qx_s2, qy_s2, qz_s2;
	logic [2*CW-1:0]      mn2_s2, mx2_s2, mn2_s3, mx2_s3;
	logic [SW-1:0]        sum_s3;
	logic [2*CW-1:0]      sq_s4;
	kind_t                kind_s4;

	assign dx = $signed({src_x[CW-1], src_x}) - $signed({lis_x[CW-1], lis_x});
	assign dy = $signed({src_y[CW-1], src_y}) - $signed({lis_y[CW-1], lis_y});
	assign dz = $signed({src_z[CW-1], src_z}) - $signed({lis_z[CW-1], lis_z});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= dx[CW] ? (~dx + 1'b1) : dx;
			ay_s1 <= dy[CW] ? (~dy + 1'b1) : dy;
			az_s1 <= dz[CW] ? (~dz + 1'b1) : dz;
			mn_s1 <= min_distance;
			mx_s1 <= max_distance;
			ro_s1 <= rolloff;
			sp_s1 <= is_spatial;

			qx_s2  <= ax_s1 * ax_s1;
			qy_s2  <= ay_s1 * ay_s1;
			qz_s2  <= az_s1 * az_s1;
			mn2_s2 <= mn_s1 * mn_s1;
			mx2_s2 <= mx_s1 * mx_s1;
			mn_s2  <= mn_s1;
			ro_s2  <= ro_s1;
			sp_s2  <= sp_s1;

			sum_s3 <= SW'(qx_s2) + SW'(qy_s2) + SW'(qz_s2);
			mn2_s3 <= mn2_s2;
			mx2_s3 <= mx2_s2;
			mn_s3  <= mn_s2;
			ro_s3  <= ro_s2;
			sp_s3  <= sp_s2;

			sq_s4 <= sum_s3[2*CW-1:0];
			mn_s4 <= mn_s3;
			ro_s4 <= ro_s3;
			if (!sp_s3 || sum_s3 <= SW'(mn2_s3))
				kind_s4 <= KIND_ONE;
			else if (sum_s3 >= SW'(mx2_s3))
				kind_s4 <= KIND_ZERO;
			else
				kind_s4 <= KIND_CALC;
		end
	end

	assign out_valid = vld_s4;
	assign sq        = sq_s4;
	assign mn        = mn_s4;
	assign ro        = ro_s4;
	assign kind      = kind_s4;

endmodule

FILE: rtl/core/dai_sqrt.sv
module dai_sqrt
	import dai_pkg::*;
#(
	parameter int CW     = COORD_WIDTH_DEF,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*CW-1:0]   sq,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [CW-1:0]     root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = CW + 2;

	logic              vld_s  [0:CW];
	logic [2*CW-1:0]   sq_s   [0:CW];
	logic [RW-1:0]     rem_s  [0:CW];
	logic [CW-1:0]     root_s [0:CW];
	logic [SIDE_W-1:0] side_s [0:CW];

	assign vld_s[0]  = in_valid;
	assign sq_s[0]   = sq;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < CW; k++) begin : g_stage
		logic [RW:0] shifted;
		logic [RW:0] trial;

		assign shifted = {rem_s[k][RW-2:0], sq_s[k][2*(CW-1-k)+1 -: 2]};
		assign trial   = shifted - {1'b0, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1]   <= sq_s[k];
				side_s[k+1] <= side_s[k];
				if (!trial[RW]) begin
					rem_s[k+1]  <= trial[RW-1:0];
					root_s[k+1] <= {root_s[k][CW-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= shifted[RW-1:0];
					root_s[k+1] <= {root_s[k][CW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[CW];
	assign root      = root_s[CW];
	assign side_out  = side_s[CW];

endmodule

FILE: rtl/core/dai_div.sv
module dai_div
	import dai_pkg::*;
#(
	parameter int CW = COORD_WIDTH_DEF,
	parameter int GF = GAIN_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [CW-1:0]        root_in,
	input  logic [CW-1:0]        mn,
	input  logic [ROLLOFF_W-1:0] ro,
	input  kind_t                kind_in,
	output logic                 out_valid,
	output logic [GF:0]          quot,
	output kind_t                kind_out
);

	localparam int DW = CW + 17;
	localparam int NW = CW + GF + 18;

	logic                  vld_sa, vld_sb;
	logic [CW+15:0]        prod_sa;
	logic [CW-1:0]         mn_sa;
	kind_t                 kind_sa;
	logic [DW-1:0]         den;
	logic [NW-1:0]         num;

	logic                  vld_s  [0:GF+1];
	logic [NW-1:0]         num_s  [0:GF+1];
	logic [DW-1:0]         den_s  [0:GF+1];
	logic [DW-1:0]         rem_s  [0:GF+1];
	logic [GF:0]           q_s    [0:GF+1];
	kind_t                 kind_s [0:GF+1];

	assign den = (DW'(mn_sa) << 8) + DW'(prod_sa);
	assign num = (NW'(mn_sa) << (8 + GF)) + NW'(den >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_sb <= 1'b0;
		end else if (en) begin
			vld_sa <= in_valid;
			vld_sb <= vld_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sa <= ro * (root_in - mn);
			mn_sa   <= mn;
			kind_sa <= kind_in;

			num_s[0]  <= num;
			den_s[0]  <= den;
			rem_s[0]  <= num[NW-1:GF+1];
			q_s[0]    <= '0;
			kind_s[0] <= (kind_sa == KIND_CALC && den == '0) ? KIND_ONE : kind_sa;
		end
	end

	assign vld_s[0] = vld_sb;

	for (genvar k = 0; k <= GF; k++) begin : g_stage
		logic [DW:0] shifted;
		logic        ge;

		assign shifted = {rem_s[k], num_s[k][GF-k]};
		assign ge      = shifted >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1]  <= num_s[k];
				den_s[k+1]  <= den_s[k];
				kind_s[k+1] <= kind_s[k];
				q_s[k+1]    <= {q_s[k][GF-1:0], ge};
				if (ge)
					rem_s[k+1] <= DW'(shifted - {1'b0, den_s[k]});
				else
					rem_s[k+1] <= shifted[DW-1:0];
			end
		end
	end

	assign out_valid = vld_s[GF+1];
	assign quot      = q_s[GF+1];
	assign kind_out  = kind_s[GF+1];

endmodule

FILE: rtl/core/distance_attenuation_inverse_clamped.sv
// inverse-distance clamped attenuation, one gain per sound source
// s_* channel: one source per word, s_tuser is the 3d flag
// cfg_* channel: listener position writes, index 0..2 = x, y, z; always ready,
// only to be written while no source is in flight
// m_* channel: one gain word per source, unsigned with GAIN_FRAC_BITS fraction
// bits, 1 << GAIN_FRAC_BITS is unity
// the square root settles one digit per stage, the divider one bit per stage
// throughput: one source per cycle while m_tready does not stall the pipeline,
// every stage is a register slice
// reset clears all valid bits and the listener position to the origin
// a stall on m_tready freezes the whole pipeline; s_tready drops with it and
// the waiting gain word holds until taken
module distance_attenuation_inverse_clamped
	import dai_pkg::*;
#(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	localparam int IN_DW  = ((5 * COORD_WIDTH + ROLLOFF_W + 7) / 8) * 8,
	localparam int OUT_DW = ((GAIN_FRAC_BITS + 1 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// src_x, src_y, src_z, min_distance, max_distance, rolloff
	input  logic [IN_DW-1:0]       s_tdata,
	// is_spatial
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// gain
	output logic [OUT_DW-1:0]      m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	localparam int CW     = COORD_WIDTH;
	localparam int GF     = GAIN_FRAC_BITS;
	localparam int SIDE_W = CW + ROLLOFF_W + 2;

	logic                 en;
	logic [CW-1:0]        lis_x_q, lis_y_q, lis_z_q;

	logic                 sd_valid;
	logic [2*CW-1:0]      sd_sq;
	logic [CW-1:0]        sd_mn;
	logic [ROLLOFF_W-1:0] sd_ro;
	kind_t                sd_kind;

	logic                 rt_valid;
	logic [CW-1:0]        rt_root;
	logic [SIDE_W-1:0]    rt_side;

	logic                 dv_valid;
	logic [GF:0]          dv_quot;
	kind_t                dv_kind;

	logic                 out_valid_q;
	logic [GF:0]          gain_q;

	assign en        = !out_valid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lis_x_q <= '0;
			lis_y_q <= '0;
			lis_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LISTENER_X: lis_x_q <= cfg_data;
				CFG_LISTENER_Y: lis_y_q <= cfg_data;
				CFG_LISTENER_Z: lis_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dai_sqdist #(.CW(CW)) u_sqdist (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.src_x       (s_tdata[CW-1:0]),
		.src_y       (s_tdata[2*CW-1:CW]),
		.src_z       (s_tdata[3*CW-1:2*CW]),
		.lis_x       (lis_x_q),
		.lis_y       (lis_y_q),
		.lis_z       (lis_z_q),
		.min_distance(s_tdata[4*CW-1:3*CW]),
		.max_distance(s_tdata[5*CW-1:4*CW]),
		.rolloff     (s_tdata[5*CW+ROLLOFF_W-1:5*CW]),
		.is_spatial  (s_tuser),
		.out_valid   (sd_valid),
		.sq          (sd_sq),
		.mn          (sd_mn),
		.ro          (sd_ro),
		.kind        (sd_kind)
	);

	dai_sqrt #(.CW(CW), .SIDE_W(SIDE_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sd_valid),
		.sq       (sd_sq),
		.side_in  ({sd_kind, sd_ro, sd_mn}),
		.out_valid(rt_valid),
		.root     (rt_root),
		.side_out (rt_side)
	);

	dai_div #(.CW(CW), .GF(GF)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rt_valid),
		.root_in  (rt_root),
		.mn       (rt_side[CW-1:0]),
		.ro       (rt_side[CW+ROLLOFF_W-1:CW]),
		.kind_in  (kind_t'(rt_side[SIDE_W-1:CW+ROLLOFF_W])),
		.out_valid(dv_valid),
		.quot     (dv_quot),
		.kind_out (dv_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (dv_kind)
				KIND_ONE:  gain_q <= (GF+1)'(1) << GF;
				KIND_ZERO: gain_q <= '0;
				KIND_CALC: gain_q <= (dv_quot > ((GF+1)'(1) << GF)) ?
				                     ((GF+1)'(1) << GF) : dv_quot;
				default:   gain_q <= '0;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DW'(gain_q);

endmodule
